/* design/ckbp_pkg.sv */
// Shared constants and register codes for the color key binarize and pack block.
package ckbp_pkg;

    localparam int PALETTE_DEPTH = 256;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 10;
    localparam int BYTES_W = 3;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_RED      = 3'd0;
    localparam logic [2:0] REG_KEY_GREEN    = 3'd1;
    localparam logic [2:0] REG_KEY_BLUE     = 3'd2;
    localparam logic [2:0] REG_THRESHOLD    = 3'd3;
    localparam logic [2:0] REG_OUT_MODE     = 3'd4;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd5;

    // Output modes; bit 1 set selects the gray byte
    localparam logic [1:0] MODE_ABOVE = 2'd0;
    localparam logic [1:0] MODE_BELOW = 2'd1;

    localparam logic FMT_DIRECT  = 1'b0;
    localparam logic FMT_PALETTE = 1'b1;

    localparam logic OP_PAL_WRITE = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    localparam logic [CHAN_W-1:0] GRAY_LOW  = 8'd3;
    localparam logic [CHAN_W-1:0] GRAY_HIGH = 8'd253;
    localparam logic [CHAN_W-1:0] GRAY_MAX  = 8'hff;

endpackage

/* design/color_key_binarize_pack_top.sv */
// Color key binarize and pack: top level with palette, distance pipeline and byte output.
//
// Accepts one item per clock unless the pipeline stalls. Opcode-0 items load a palette
// entry (PALETTE_DEPTH x 24-bit RAM, registered read, no clearing after reset: read an entry
// only after writing it). Opcode-1 items are pixels, direct RGB or palette indexed; each
// passes a palette read, an absolute-difference sum and a divide-by-3 / compare stage before
// reaching the output register. The output port moves one byte per cycle while m_axis_tready
// is high: a binary pixel yields a byte every eighth pixel, a gray pixel one byte, and a row
// end flushes the partial byte and pads with zeros to a multiple of four bytes, so a row-end
// pixel holds the input while its bytes drain. Configuration is sampled live and must only
// change while idle.
module color_key_binarize_pack_top #(
    parameter int PALETTE_DEPTH = ckbp_pkg::PALETTE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // pixel / palette input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [7:0] pixel_index, [15:8] red, [23:16] green,
                                       // [31:24] blue
    input  logic        s_axis_tuser,  // [0] opcode
    input  logic        s_axis_tlast,  // row_end
    // byte output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast   // row_done
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = ckbp_pkg::CHAN_W;
    localparam int SW = ckbp_pkg::SUM_W;
    localparam int BW = ckbp_pkg::BYTES_W;

    // configuration registers
    logic [CW-1:0] r_key_red, r_key_green, r_key_blue, r_threshold;
    logic [1:0]    r_out_mode;
    logic          r_pixel_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_red      <= '0;
            r_key_green    <= '0;
            r_key_blue     <= '0;
            r_threshold    <= '0;
            r_out_mode     <= ckbp_pkg::MODE_ABOVE;
            r_pixel_format <= ckbp_pkg::FMT_DIRECT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ckbp_pkg::REG_KEY_RED:      r_key_red      <= i_cfg_data;
                ckbp_pkg::REG_KEY_GREEN:    r_key_green    <= i_cfg_data;
                ckbp_pkg::REG_KEY_BLUE:     r_key_blue     <= i_cfg_data;
                ckbp_pkg::REG_THRESHOLD:    r_threshold    <= i_cfg_data;
                ckbp_pkg::REG_OUT_MODE:     r_out_mode     <= i_cfg_data[1:0];
                ckbp_pkg::REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input decode
    logic [7:0]  in_index;
    logic        in_accept, in_range;
    logic [ckbp_pkg::COLOR_W-1:0] in_color, pal_q;

    assign in_index  = s_axis_tdata[7:0];
    assign in_color  = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = ({1'b0, in_index} < 9'(PALETTE_DEPTH));

    ckbp_ram #(
        .WIDTH (ckbp_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (in_accept && (s_axis_tuser == ckbp_pkg::OP_PAL_WRITE) && in_range),
        .i_waddr (in_index[AW-1:0]),
        .i_wdata (in_color),
        .i_re    (in_accept && (s_axis_tuser == ckbp_pkg::OP_PIXEL)),
        .i_raddr (in_index[AW-1:0]),
        .o_rdata (pal_q)
    );

    // pipeline control
    logic s1_go, s2_take, s2_go, ob_free;
    logic [BW-1:0] s2_n;

    // stage 1: pixel fields beside the palette read data
    logic                         r_s1_valid, r_s1_in_range, r_s1_last;
    logic [ckbp_pkg::COLOR_W-1:0] r_s1_color;

    assign s1_go         = r_s1_valid && s2_take;
    assign s_axis_tready = !r_s1_valid || s2_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= in_accept && (s_axis_tuser == ckbp_pkg::OP_PIXEL);
        end
        if (in_accept) begin
            r_s1_color    <= in_color;
            r_s1_in_range <= in_range;
            r_s1_last     <= s_axis_tlast;
        end
    end

    logic [ckbp_pkg::COLOR_W-1:0] s1_color;
    logic [CW-1:0] d_red, d_green, d_blue;

    always_comb begin
        if (r_pixel_format == ckbp_pkg::FMT_PALETTE) begin
            s1_color = r_s1_in_range ? pal_q : '0;
        end else begin
            s1_color = r_s1_color;
        end
        d_red   = (s1_color[23:16] > r_key_red) ? s1_color[23:16] - r_key_red
                                                : r_key_red - s1_color[23:16];
        d_green = (s1_color[15:8] > r_key_green) ? s1_color[15:8] - r_key_green
                                                 : r_key_green - s1_color[15:8];
        d_blue  = (s1_color[7:0] > r_key_blue) ? s1_color[7:0] - r_key_blue
                                               : r_key_blue - s1_color[7:0];
    end

    // stage 2: distance sum
    logic          r_s2_valid, r_s2_last;
    logic [SW-1:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_take) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s1_go) begin
            r_s2_sum  <= SW'(d_red) + SW'(d_green) + SW'(d_blue);
            r_s2_last <= r_s1_last;
        end
    end

    // stage 2 logic: divide, compare, pack
    logic [7:0]     r_bit_acc;
    logic [2:0]     r_bit_cnt;
    logic [1:0]     r_phase;

    logic [2*SW-1:0] prod;
    logic [CW-1:0]   pix_dist, gray_val, data_byte, n_bit_acc;
    logic            gray, pix_bit, full, has_data;
    logic [2:0]      n_bit_cnt;
    logic [1:0]      phase_after, pad, n_phase;

    always_comb begin
        prod     = r_s2_sum * ckbp_pkg::DIV3_MUL;
        pix_dist = prod[ckbp_pkg::DIV3_SHIFT +: CW];
        gray     = r_out_mode[1];
        pix_bit  = (r_out_mode == ckbp_pkg::MODE_ABOVE) ? (pix_dist > r_threshold)
                                                        : (pix_dist < r_threshold);
        if (pix_dist < ckbp_pkg::GRAY_LOW) begin
            gray_val = '0;
        end else if (pix_dist > ckbp_pkg::GRAY_HIGH) begin
            gray_val = ckbp_pkg::GRAY_MAX;
        end else begin
            gray_val = pix_dist;
        end

        n_bit_acc = r_bit_acc | (pix_bit ? (8'h80 >> r_bit_cnt) : 8'h00);
        full      = (r_bit_cnt == 3'd7);

        if (gray) begin
            has_data  = 1'b1;
            data_byte = gray_val;
            n_bit_acc = r_bit_acc;
            n_bit_cnt = r_bit_cnt;
        end else begin
            // flush a partial byte at row end, emit a full one at once
            has_data  = full || r_s2_last;
            data_byte = n_bit_acc;
            n_bit_cnt = r_bit_cnt + 3'd1;
            if (full) begin
                n_bit_acc = '0;
            end
        end

        phase_after = r_phase + {1'b0, has_data};
        pad         = r_s2_last ? 2'(-phase_after) : 2'd0;
        s2_n        = BW'(has_data) + BW'(pad);
        n_phase     = r_s2_last ? 2'd0 : phase_after;
        if (r_s2_last) begin
            n_bit_acc = '0;
            n_bit_cnt = '0;
        end
    end

    assign s2_go   = r_s2_valid && ((s2_n == '0) || ob_free);
    assign s2_take = !r_s2_valid || s2_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_acc <= '0;
            r_bit_cnt <= '0;
            r_phase   <= '0;
        end else if (s2_go) begin
            r_bit_acc <= n_bit_acc;
            r_bit_cnt <= n_bit_cnt;
            r_phase   <= n_phase;
        end
    end

    // output register: one data byte followed by zero padding
    logic          r_ob_valid, r_ob_last;
    logic [CW-1:0] r_ob_byte;
    logic [BW-1:0] r_ob_left;
    logic          out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign ob_free  = !r_ob_valid || (m_axis_tready && (r_ob_left == BW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_left  <= '0;
        end else if (s2_go && (s2_n != '0)) begin
            r_ob_valid <= 1'b1;
            r_ob_left  <= s2_n;
        end else if (out_xfer) begin
            r_ob_valid <= (r_ob_left != BW'(1));
            r_ob_left  <= r_ob_left - BW'(1);
        end
        if (s2_go && (s2_n != '0)) begin
            r_ob_byte <= has_data ? data_byte : '0;
            r_ob_last <= r_s2_last;
        end else if (out_xfer) begin
            r_ob_byte <= '0;
        end
    end

    assign m_axis_tvalid = r_ob_valid;
    assign m_axis_tdata  = r_ob_byte;
    assign m_axis_tlast  = r_ob_last && (r_ob_left == BW'(1));

    // checks
    a_ob_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_valid |-> (r_ob_left != '0) && (r_ob_left <= BW'(4)))
        else $error("output byte count out of range");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2_last) |=> (r_bit_cnt == '0) && (r_phase == '0) && (r_bit_acc == '0))
        else $error("row end left packing state behind");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && (r_ob_left > BW'(1))) |=> (m_axis_tdata == '0))
        else $error("padding byte not zero");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_s2_valid && r_ob_valid)
        else $error("input stalled with free pipeline slot");

endmodule

/* design/ckbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ckbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
